### design/shac_pkg.sv
// Shared types, constants and search functions of the subregion heap allocator.
// Used by the controller, the datapath and the top level; depends on nothing.
package shac_pkg;

    localparam int SUBREG_COUNT = 40;
    localparam int MAP_W        = 40;
    localparam int SUB_W        = 6;
    localparam int OWNER_W      = 8;
    localparam int SIZE_W       = 16;
    localparam int ADDR_W       = 32;
    localparam int BYTES_W      = 14;
    localparam int FREED_W      = 5;
    localparam int RUN_W        = 4;
    localparam int REC_W        = OWNER_W + SUB_W + BYTES_W;

    // Input operation codes
    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    // Size class limits and group offsets
    localparam logic [SIZE_W-1:0] MAX_BYTES   = 16'h2000;
    localparam logic [SIZE_W-1:0] SMALL_BYTES = 16'h0200;
    localparam logic [SIZE_W-1:0] LARGE_BYTES = 16'h0400;
    localparam logic [SIZE_W-1:0] EDGE_BYTES  = 16'h0600;
    localparam logic [SIZE_W-1:0] SPLIT_BYTES = 16'h1000;
    localparam logic [15:0] OFS_GROUP1 = 16'h1000;
    localparam logic [15:0] OFS_GROUP2 = 16'h3000;
    localparam logic [15:0] OFS_GROUP3 = 16'h5000;

    typedef struct packed {
        logic                capture;
        logic                alloc_eval;
        logic                alloc_commit;
        logic                find_eval;
        logic                comp_eval;
        logic                comp_done;
        logic                emit;
    } shac_cmd_t;

    typedef struct packed {
        logic                scan_end;
        logic                hit;
        logic                out_free;
    } shac_stat_t;

    typedef struct packed {
        logic                found;
        logic [SUB_W-1:0]    start;
        logic [RUN_W-1:0]    n;
        logic [BYTES_W-1:0]  bytes;
    } shac_fit_t;

    // Byte offset of a subregion from the heap base
    function automatic logic [15:0] sub_offset(input logic [SUB_W-1:0] s);
        logic [15:0] ofs;
        if (s < 6'd8) begin
            ofs = {4'd0, s[2:0], 9'd0};
        end else if (s < 6'd16) begin
            ofs = OFS_GROUP1 + {3'd0, s[2:0], 10'd0};
        end else if (s < 6'd32) begin
            ofs = OFS_GROUP2 + {3'd0, s[3:0], 9'd0};
        end else begin
            ofs = OFS_GROUP3 + {3'd0, s[2:0], 10'd0};
        end
        return ofs;
    endfunction

    // Mask of n subregions starting at start, clipped at the map end
    function automatic logic [MAP_W-1:0] run_mask(input logic [SUB_W-1:0] start,
                                                 input logic [RUN_W-1:0] n);
        logic [MAP_W-1:0] m;
        m = '0;
        for (int k = 0; k < MAP_W; k++) begin
            m[k] = (k >= int'(start)) && (k < int'(start) + int'(n));
        end
        return m;
    endfunction

    // First free run of n subregions in [lo, hi); bit 6 flags a find
    function automatic logic [SUB_W:0] find_run(input logic [MAP_W-1:0] map,
                                               input int lo, input int hi,
                                               input logic [RUN_W-1:0] n);
        logic [SUB_W:0] res;
        logic           ok;
        res = '0;
        for (int j = MAP_W - 1; j >= 0; j--) begin
            ok = (j >= lo) && (j + int'(n) <= hi);
            for (int k = 0; k < 8; k++) begin
                if (k < int'(n) && (j + k) < MAP_W) begin
                    if (map[j + k]) ok = 1'b0;
                end
            end
            if (ok) res = {1'b1, SUB_W'(j)};
        end
        return res;
    endfunction

    // Subregions held by a record
    function automatic logic [RUN_W-1:0] used_subregs(input logic [SUB_W-1:0] start,
                                                     input logic [BYTES_W-1:0] size);
        logic wide_unit;
        wide_unit = (start >= 6'd8 && start < 6'd16) || (start >= 6'd32);
        if ((start == 6'd7 || start == 6'd15 || start == 6'd31) &&
            size == BYTES_W'(EDGE_BYTES)) begin
            return RUN_W'(2);
        end else if (wide_unit) begin
            return size[13:10];
        end else begin
            return size[12:9];
        end
    endfunction

    // First fit for a request size against the occupancy map
    function automatic shac_fit_t alloc_search(input logic [MAP_W-1:0] map,
                                               input logic [SIZE_W-1:0] sz);
        shac_fit_t      f;
        logic [SUB_W:0] r;
        logic [16:0]    up_s;
        logic [16:0]    up_l;
        f    = '0;
        r    = '0;
        up_s = {1'b0, sz} + 17'h01FF;
        up_l = {1'b0, sz} + 17'h03FF;
        if (sz == '0 || sz > MAX_BYTES) begin
            r = '0;
        end else if (sz <= SMALL_BYTES) begin
            f.n     = RUN_W'(1);
            f.bytes = BYTES_W'(SMALL_BYTES);
            r = find_run(map, 0, 8, f.n);
            if (!r[SUB_W]) r = find_run(map, 16, 32, f.n);
            if (!r[SUB_W]) begin
                f.bytes = BYTES_W'(LARGE_BYTES);
                r = find_run(map, 8, 16, f.n);
                if (!r[SUB_W]) r = find_run(map, 32, 40, f.n);
            end
        end else if (sz <= LARGE_BYTES) begin
            f.n     = RUN_W'(1);
            f.bytes = BYTES_W'(LARGE_BYTES);
            r = find_run(map, 8, 16, f.n);
            if (!r[SUB_W]) r = find_run(map, 32, 40, f.n);
        end else if (sz <= EDGE_BYTES) begin
            f.bytes = BYTES_W'(EDGE_BYTES);
            f.n     = RUN_W'(2);
            if (map[8:7] == 2'b00) begin
                r = {1'b1, 6'd7};
            end else if (map[16:15] == 2'b00) begin
                r = {1'b1, 6'd15};
            end else if (map[32:31] == 2'b00) begin
                r = {1'b1, 6'd31};
            end else begin
                f.n = RUN_W'(3);
                r = find_run(map, 0, 8, f.n);
                if (!r[SUB_W]) r = find_run(map, 16, 32, f.n);
            end
        end else if (sz <= SPLIT_BYTES) begin
            f.n     = up_s[12:9];
            f.bytes = {1'b0, up_s[12:9], 9'd0};
            r = find_run(map, 0, 8, f.n);
            if (!r[SUB_W]) r = find_run(map, 16, 32, f.n);
            if (!r[SUB_W]) begin
                f.n     = up_l[13:10];
                f.bytes = {up_l[13:10], 10'd0};
                r = find_run(map, 8, 16, f.n);
                if (!r[SUB_W]) r = find_run(map, 32, 40, f.n);
            end
        end else begin
            f.n     = up_l[13:10];
            f.bytes = {up_l[13:10], 10'd0};
            r = find_run(map, 8, 16, f.n);
            if (!r[SUB_W]) r = find_run(map, 32, 40, f.n);
        end
        f.found = r[SUB_W];
        f.start = r[SUB_W-1:0];
        return f;
    endfunction

endpackage

### design/shac_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; used for the allocation record table.
module shac_ram #(
    parameter int WIDTH = 28,
    parameter int DEPTH = 16
) (
    input  logic                                   aclk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port and registered read port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### design/shac_ctrl.sv
// Sequencer of the heap allocator: steps through search, commit, table scan
// and compaction. Depends on shac_pkg for the command and status structs.
module shac_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                in_valid,
    input  logic                in_op,
    output logic                in_ready,
    input  shac_pkg::shac_stat_t stat,
    output shac_pkg::shac_cmd_t  cmd
);

    localparam logic [2:0] ST_IDLE    = 3'd0;
    localparam logic [2:0] ST_SEARCH  = 3'd1;
    localparam logic [2:0] ST_COMMIT  = 3'd2;
    localparam logic [2:0] ST_FIND_RD = 3'd3;
    localparam logic [2:0] ST_FIND_EV = 3'd4;
    localparam logic [2:0] ST_COMP_RD = 3'd5;
    localparam logic [2:0] ST_COMP_EV = 3'd6;
    localparam logic [2:0] ST_DONE    = 3'd7;

    logic [2:0] state_reg, state_next;

    assign in_ready = (state_reg == ST_IDLE);

    // Next state and commands
    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = (in_op == shac_pkg::OP_FREE) ? ST_FIND_RD : ST_SEARCH;
                end
            end
            ST_SEARCH: begin
                cmd.alloc_eval = 1'b1;
                state_next     = ST_COMMIT;
            end
            ST_COMMIT: begin
                cmd.alloc_commit = 1'b1;
                state_next       = ST_DONE;
            end
            ST_FIND_RD: begin
                state_next = stat.scan_end ? ST_DONE : ST_FIND_EV;
            end
            ST_FIND_EV: begin
                cmd.find_eval = 1'b1;
                state_next    = stat.hit ? ST_COMP_RD : ST_FIND_RD;
            end
            ST_COMP_RD: begin
                if (stat.scan_end) begin
                    cmd.comp_done = 1'b1;
                    state_next    = ST_DONE;
                end else begin
                    state_next = ST_COMP_EV;
                end
            end
            ST_COMP_EV: begin
                cmd.comp_eval = 1'b1;
                state_next    = ST_COMP_RD;
            end
            ST_DONE: begin
                if (stat.out_free) begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // State register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### design/shac_datapath.sv
// Datapath of the heap allocator: occupancy map, record table, scan indices
// and the result register. Depends on shac_pkg and shac_ram.
module shac_datapath #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  shac_pkg::shac_cmd_t            cmd,
    output shac_pkg::shac_stat_t           stat,
    input  logic                           cfg_we,
    input  logic [shac_pkg::ADDR_W-1:0]    cfg_wdata,
    input  logic [shac_pkg::SIZE_W-1:0]    in_bytes,
    input  logic [shac_pkg::OWNER_W-1:0]   in_owner,
    input  logic [shac_pkg::ADDR_W-1:0]    in_addr,
    input  logic                           out_ready,
    output logic                           out_valid,
    output logic                           out_granted,
    output logic [shac_pkg::ADDR_W-1:0]    out_base,
    output logic [shac_pkg::BYTES_W-1:0]   out_bytes,
    output logic [shac_pkg::FREED_W-1:0]   out_freed,
    output logic [shac_pkg::MAP_W-1:0]     out_map
);

    localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
    localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

    logic [shac_pkg::ADDR_W-1:0]  heap_base_reg;
    logic [shac_pkg::MAP_W-1:0]   map_reg;
    logic [CNT_W-1:0]             count_reg;
    logic [CNT_W-1:0]             rd_reg;
    logic [CNT_W-1:0]             wr_reg;
    logic [CNT_W-1:0]             freed_reg;
    logic [shac_pkg::OWNER_W-1:0] victim_reg;
    logic [shac_pkg::SIZE_W-1:0]  size_reg;
    logic [shac_pkg::OWNER_W-1:0] owner_reg;
    logic [shac_pkg::ADDR_W-1:0]  addr_reg;
    shac_pkg::shac_fit_t          fit_reg;
    logic                         res_granted_reg;
    logic [shac_pkg::ADDR_W-1:0]  res_base_reg;
    logic [shac_pkg::BYTES_W-1:0] res_bytes_reg;
    logic                         out_valid_reg;

    logic                         ram_we;
    logic [IDX_W-1:0]             ram_waddr;
    logic [shac_pkg::REC_W-1:0]   ram_wdata;
    logic [shac_pkg::REC_W-1:0]   ram_rdata;
    logic [shac_pkg::OWNER_W-1:0] rec_owner;
    logic [shac_pkg::SUB_W-1:0]   rec_start;
    logic [shac_pkg::BYTES_W-1:0] rec_size;
    logic [shac_pkg::ADDR_W-1:0]  rec_end;
    logic                         commit_ok;
    logic                         victim_match;

    // Record fields: owner, start subregion, reserved bytes
    assign rec_owner = ram_rdata[shac_pkg::REC_W-1 -: shac_pkg::OWNER_W];
    assign rec_start = ram_rdata[shac_pkg::BYTES_W +: shac_pkg::SUB_W];
    assign rec_size  = ram_rdata[shac_pkg::BYTES_W-1:0];
    assign rec_end   = heap_base_reg + {16'd0, shac_pkg::sub_offset(rec_start)}
                     + {18'd0, rec_size};

    assign commit_ok    = fit_reg.found && (count_reg < CNT_W'(TABLE_DEPTH));
    assign victim_match = (rec_owner == victim_reg);

    // Table write: new record on commit, kept record on compaction
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = count_reg[IDX_W-1:0];
        ram_wdata = {owner_reg, fit_reg.start, fit_reg.bytes};
        if (cmd.alloc_commit && commit_ok) begin
            ram_we = 1'b1;
        end else if (cmd.comp_eval && !victim_match) begin
            ram_we    = 1'b1;
            ram_waddr = wr_reg[IDX_W-1:0];
            ram_wdata = ram_rdata;
        end
    end

    shac_ram #(
        .WIDTH (shac_pkg::REC_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (rd_reg[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    assign stat.scan_end = (rd_reg == count_reg);
    assign stat.hit      = (rec_end == addr_reg);
    assign stat.out_free = !out_valid_reg || out_ready;

    // Control state: base register, map, count, output valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            heap_base_reg <= '0;
            map_reg       <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cfg_we) begin
                heap_base_reg <= cfg_wdata;
            end
            if (cmd.alloc_commit && commit_ok) begin
                map_reg   <= map_reg | shac_pkg::run_mask(fit_reg.start, fit_reg.n);
                count_reg <= count_reg + CNT_W'(1);
            end
            if (cmd.comp_eval && victim_match) begin
                map_reg <= map_reg & ~shac_pkg::run_mask(rec_start,
                               shac_pkg::used_subregs(rec_start, rec_size));
            end
            if (cmd.comp_done) begin
                count_reg <= wr_reg;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Working registers of one item
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            size_reg        <= in_bytes;
            owner_reg       <= in_owner;
            addr_reg        <= in_addr;
            rd_reg          <= '0;
            wr_reg          <= '0;
            freed_reg       <= '0;
            res_granted_reg <= 1'b0;
            res_base_reg    <= '0;
            res_bytes_reg   <= '0;
        end
        if (cmd.alloc_eval) begin
            fit_reg <= shac_pkg::alloc_search(map_reg, size_reg);
        end
        if (cmd.alloc_commit && commit_ok) begin
            res_granted_reg <= 1'b1;
            res_base_reg    <= heap_base_reg + {16'd0, shac_pkg::sub_offset(fit_reg.start)};
            res_bytes_reg   <= fit_reg.bytes;
        end
        // Scan for the matching end address, then restart for compaction
        if (cmd.find_eval) begin
            if (stat.hit) begin
                victim_reg <= rec_owner;
                rd_reg     <= '0;
            end else begin
                rd_reg <= rd_reg + CNT_W'(1);
            end
        end
        if (cmd.comp_eval) begin
            rd_reg <= rd_reg + CNT_W'(1);
            if (victim_match) begin
                freed_reg <= freed_reg + CNT_W'(1);
            end else begin
                wr_reg <= wr_reg + CNT_W'(1);
            end
        end
        if (cmd.comp_done) begin
            res_granted_reg <= 1'b1;
        end
        // Load the result item
        if (cmd.emit) begin
            out_granted <= res_granted_reg;
            out_base    <= res_base_reg;
            out_bytes   <= res_bytes_reg;
            out_freed   <= shac_pkg::FREED_W'(freed_reg);
            out_map     <= map_reg;
        end
    end

    assign out_valid = out_valid_reg;

endmodule

### design/subregion_heap_allocator.sv
// Subregion heap allocator, top level: stream ports, sequencer and datapath.
// An allocate passes the search and commit states to the result register; a free scans the
// table for the record whose end address matches, then compacts it (a miss skips compaction).
// One item at a time, the next taken in the cycle after the result is loaded;
// the table scan and compaction read one record at a time, a read state then an evaluate state.
// Reset (synchronous, active low) empties the map and table and zeroes heap_base.
module subregion_heap_allocator #(
    parameter int TABLE_DEPTH = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         cfg_we,
    input  logic [31:0]  cfg_wdata,     // heap_base
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [55:0]  s_tdata,       // request_bytes[15:0], owner_id[23:16], stack_address[55:24]
    input  logic         s_tuser,       // operation
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [95:0]  m_tdata,       // base_address[31:0], block_bytes[45:32],
                                        // freed_records[50:46], in_use_map[90:51], zero fill
    output logic         m_tuser        // granted
);

    shac_pkg::shac_cmd_t  cmd;
    shac_pkg::shac_stat_t stat;
    logic [31:0]          out_base;
    logic [13:0]          out_bytes;
    logic [4:0]           out_freed;
    logic [39:0]          out_map;

    shac_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in_valid (s_tvalid),
        .in_op    (s_tuser),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    shac_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .in_bytes    (s_tdata[15:0]),
        .in_owner    (s_tdata[23:16]),
        .in_addr     (s_tdata[55:24]),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_granted (m_tuser),
        .out_base    (out_base),
        .out_bytes   (out_bytes),
        .out_freed   (out_freed),
        .out_map     (out_map)
    );

    // Pack the result item
    assign m_tdata = {5'd0, out_map, out_freed, out_bytes, out_base};

endmodule
